@@ design/stmm_pkg.sv @@
// Shared types and codes for the stereo-to-mono delay-and-sum mixer.
// No dependencies; imported by every module of the block.
package stmm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int MODE_W      = 3;
  localparam int DELAY_W     = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;
  localparam int DEPTH_DEFAULT = 64;

  // mix_mode codes; unused codes fall back to average
  localparam logic [MODE_W-1:0] MODE_LEFT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RIGHT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CHOSEN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DSUM    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AVERAGE = 3'd4;

  // register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] REG_MIX_MODE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY    = 4'd1;

  localparam logic [MODE_W-1:0]  MIX_MODE_RESET = MODE_CHOSEN;
  localparam logic [DELAY_W-1:0] DELAY_RESET    = 8'd0;

  typedef struct packed {
    logic [MODE_W-1:0]         mix_mode;
    logic signed [DELAY_W-1:0] delay_samples;
  } stmm_cfg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

@@ design/stmm_history.sv @@
// Delay lines for both channels: two sample memories, write pointer and fill count.
// Depends on stmm_pkg.
module stmm_history import stmm_pkg::*; #(
  parameter int DELAY_DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stmm_cfg_t cfg_i,
  input  logic      rd_en_i,     // load read registers (stage 1 advances)
  input  logic      wr_en_i,     // accepted beat in delay-and-sum with nonzero delay
  input  sample_t   left_i,
  input  sample_t   right_i,
  output sample_t   left_rd_o,
  output sample_t   right_rd_o
);

  localparam int PTR_W = $clog2(DELAY_DEPTH);
  localparam int CNT_W = $clog2(DELAY_DEPTH + 1);
  localparam int CW    = (CNT_W > DELAY_W) ? CNT_W : DELAY_W;

  sample_t left_mem  [DELAY_DEPTH];
  sample_t right_mem [DELAY_DEPTH];

  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             full;

  logic [DELAY_W-1:0] mag;
  logic [CW-1:0]      mag_ext, sat_mag;
  logic [CW:0]        rd_sum, rd_wrap;
  logic [PTR_W-1:0]   rd_addr;
  logic               rd_hit;

  sample_t left_rd_q, right_rd_q;
  logic    hit_q;

  assign full = (fill_q == CNT_W'(DELAY_DEPTH));

  // magnitude of the signed delay, clamped to the line length
  always_comb begin
    mag     = cfg_i.delay_samples[DELAY_W-1] ? DELAY_W'(-cfg_i.delay_samples)
                                             : DELAY_W'(cfg_i.delay_samples);
    mag_ext = CW'(mag);
    sat_mag = (mag_ext > CW'(DELAY_DEPTH)) ? CW'(DELAY_DEPTH) : mag_ext;
    rd_sum  = (CW+1)'(ptr_q) + (CW+1)'(DELAY_DEPTH) - (CW+1)'(sat_mag);
    rd_wrap = (rd_sum >= (CW+1)'(DELAY_DEPTH)) ? rd_sum - (CW+1)'(DELAY_DEPTH) : rd_sum;
    rd_addr = rd_wrap[PTR_W-1:0];
    // entries are written in order from zero, so [0, fill) holds data
    rd_hit  = full || ((CW+1)'(rd_addr) < (CW+1)'(fill_q));
  end

  always_comb begin
    ptr_d  = ptr_q;
    fill_d = fill_q;
    if (wr_en_i) begin
      ptr_d = (ptr_q == PTR_W'(DELAY_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);
      if (!full) begin
        fill_d = fill_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
    end else begin
      ptr_q  <= ptr_d;
      fill_q <= fill_d;
    end
  end

  // read-first: a full-length delay reads the slot being overwritten
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      left_mem[ptr_q]  <= left_i;
      right_mem[ptr_q] <= right_i;
    end
    if (rd_en_i) begin
      left_rd_q  <= left_mem[rd_addr];
      right_rd_q <= right_mem[rd_addr];
      hit_q      <= rd_hit;
    end
  end

  assign left_rd_o  = hit_q ? left_rd_q  : '0;
  assign right_rd_o = hit_q ? right_rd_q : '0;

endmodule

@@ design/stmm_mix.sv @@
// Mixing datapath: mode select and truncating average of two samples.
// Depends on stmm_pkg.
module stmm_mix import stmm_pkg::*; (
  input  stmm_cfg_t cfg_i,
  input  sample_t   left_i,
  input  sample_t   right_i,
  input  logic      chosen_channel_i,
  input  sample_t   left_hist_i,
  input  sample_t   right_hist_i,
  output sample_t   mono_o
);

  // (a + b) / 2 toward zero; result always fits 16 bits, so no clamp is needed
  function automatic sample_t avg2(input sample_t a, input sample_t b);
    logic signed [SAMPLE_W:0] sum;
    logic signed [SAMPLE_W:0] adj;
    sum = (SAMPLE_W+1)'(a) + (SAMPLE_W+1)'(b);
    adj = sum + (SAMPLE_W+1)'(sum[SAMPLE_W]);
    return adj[SAMPLE_W:1];
  endfunction

  sample_t a_sel, b_sel;

  always_comb begin
    a_sel = left_i;
    b_sel = right_i;
    if (cfg_i.delay_samples > 0) begin
      b_sel = right_hist_i;
    end else if (cfg_i.delay_samples < 0) begin
      a_sel = left_hist_i;
    end
  end

  always_comb begin
    case (cfg_i.mix_mode)
      MODE_LEFT:   mono_o = left_i;
      MODE_RIGHT:  mono_o = right_i;
      MODE_CHOSEN: mono_o = chosen_channel_i ? right_i : left_i;
      MODE_DSUM:   mono_o = avg2(a_sel, b_sel);
      default:     mono_o = avg2(left_i, right_i);
    endcase
  end

endmodule

@@ design/stereo_to_mono_delay_sum_mixer_unit.sv @@
// Top level of the stereo-to-mono delay-and-sum mixer: config registers, pipeline, handshakes.
// Depends on stmm_pkg, stmm_history and stmm_mix.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o left_sample_i, right_sample_i, chosen_channel_i
//   out      source     out_valid_o / out_stall_i  mono_sample_o
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while out is not stalled; each beat passes through the
// history read register, then the result register. Delay-line reads use one read
// port per channel memory, registered. Reset clears the pointer and fill count;
// history entries not yet written read as zero. A stall on out holds the result
// register; stage 1 keeps accepting until it is also occupied.
module stereo_to_mono_delay_sum_mixer_unit import stmm_pkg::*; #(
  parameter int DELAY_DEPTH = DEPTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [15:0]     left_sample_i,
  input  logic signed [15:0]     right_sample_i,
  input  logic                   chosen_channel_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [15:0]     mono_sample_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  stmm_cfg_t cfg_q;

  logic    s1_valid_q;
  sample_t s1_left_q, s1_right_q;
  logic    s1_chan_q;
  logic    out_valid_q;
  sample_t mono_q;

  logic    out_en, s1_en, in_accept, hist_wr;
  sample_t left_hist, right_hist, mono_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mix_mode      <= MIX_MODE_RESET;
      cfg_q.delay_samples <= DELAY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MIX_MODE: cfg_q.mix_mode      <= cfg_data_i[MODE_W-1:0];
        REG_DELAY:    cfg_q.delay_samples <= cfg_data_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_en    = !out_valid_q || !out_stall_i;
  assign s1_en     = !s1_valid_q || out_en;
  assign in_stall_o = !s1_en;
  assign in_accept = in_valid_i && s1_en;
  assign hist_wr   = in_accept && (cfg_q.mix_mode == MODE_DSUM) &&
                     (cfg_q.delay_samples != '0);

  stmm_history #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .rd_en_i   (s1_en),
    .wr_en_i   (hist_wr),
    .left_i    (left_sample_i),
    .right_i   (right_sample_i),
    .left_rd_o (left_hist),
    .right_rd_o(right_hist)
  );

  stmm_mix u_mix (
    .cfg_i           (cfg_q),
    .left_i          (s1_left_q),
    .right_i         (s1_right_q),
    .chosen_channel_i(s1_chan_q),
    .left_hist_i     (left_hist),
    .right_hist_i    (right_hist),
    .mono_o          (mono_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_left_q  <= left_sample_i;
      s1_right_q <= right_sample_i;
      s1_chan_q  <= chosen_channel_i;
    end
    if (out_en) begin
      mono_q <= mono_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mono_sample_o = mono_q;

  // input backpressure only when both stages hold beats and out is stalled
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // an accepted beat lands in stage 1
  a_accept_loads_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted beat lost before stage 1");

  // a stage-1 beat moving on becomes a visible result
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_en) |=> out_valid_o)
    else $error("stage-1 beat dropped");

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for stereo_to_mono_delay_sum_mixer_unit: directed mode and delay cases,
// then randomized traffic with bursty input, patterned output stalls and register changes.
// Depends on stmm_pkg and the mixer RTL.
`timescale 1ns / 1ps

module tb_top;
  import stmm_pkg::*;

  localparam int HIST_DEPTH = DEPTH_DEFAULT;
  localparam int IDLE_LIMIT = 5000;

  // codes the block does not name; they mix as an average
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  sample_t                left_sample_i;
  sample_t                right_sample_i;
  logic                   chosen_channel_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  sample_t                mono_sample_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  stereo_to_mono_delay_sum_mixer_unit #(
    .DELAY_DEPTH(HIST_DEPTH)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .left_sample_i   (left_sample_i),
    .right_sample_i  (right_sample_i),
    .chosen_channel_i(chosen_channel_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mono_sample_o   (mono_sample_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // mixer state as the bench tracks it
  logic [MODE_W-1:0]         mode_q;
  logic signed [DELAY_W-1:0] delay_q;
  sample_t                   left_hist[HIST_DEPTH];
  sample_t                   right_hist[HIST_DEPTH];
  int unsigned               hist_ptr;

  sample_t mono_expected_q[$];
  int      err_count;
  int      idle_count;
  int      stall_cycle;
  int      stall_style;

  function automatic sample_t halve_sum(int a, int b);
    int s;
    s = (a + b) / 2;  // int division truncates toward zero
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return sample_t'(s);
  endfunction

  function automatic sample_t mix_pair(sample_t l, sample_t r, logic ch);
    int      mag;
    int      rd;
    sample_t res;
    case (mode_q)
      MODE_LEFT:   res = l;
      MODE_RIGHT:  res = r;
      MODE_CHOSEN: res = ch ? r : l;
      MODE_DSUM: begin
        mag = (delay_q < 0) ? -int'(delay_q) : int'(delay_q);
        if (mag == 0) begin
          res = halve_sum(l, r);
        end else begin
          if (mag > HIST_DEPTH) mag = HIST_DEPTH;
          rd = (hist_ptr + HIST_DEPTH - mag) % HIST_DEPTH;
          if (delay_q > 0) res = halve_sum(l, right_hist[rd]);
          else res = halve_sum(left_hist[rd], r);
          left_hist[hist_ptr]  = l;
          right_hist[hist_ptr] = r;
          hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
        end
      end
      default:     res = halve_sum(l, r);
    endcase
    return res;
  endfunction

  // ---------------- channel drivers ----------------

  // leaves in_valid_i high so that a following beat goes out back to back
  task automatic send_pair(input sample_t l, input sample_t r, input logic ch);
    in_valid_i       <= 1'b1;
    left_sample_i    <= l;
    right_sample_i   <= r;
    chosen_channel_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    mono_expected_q.push_back(mix_pair(l, r, ch));
  endtask

  task automatic idle_cycles(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (mono_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_MIX_MODE) mode_q = data[MODE_W-1:0];
    else if (idx == REG_DELAY) delay_q = data;
  endtask

  // called only with the block drained; the pause covers the two-stage pipeline
  task automatic configure(input logic [MODE_W-1:0] mode, input logic signed [DELAY_W-1:0] delay);
    repeat (2) @(posedge clk_i);
    write_reg(REG_MIX_MODE, CFG_DATA_W'(mode));
    write_reg(REG_DELAY, CFG_DATA_W'(delay));
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------- random sources ----------------

  function automatic sample_t random_sample();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return sample_t'(int'($urandom_range(8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] random_mode();
    int r;
    r = $urandom_range(11);
    if (r < 4) return MODE_DSUM;
    return MODE_W'(r - 4);
  endfunction

  function automatic logic signed [DELAY_W-1:0] random_delay();
    case ($urandom_range(9))
      0:       return '0;
      1:       return DELAY_W'(HIST_DEPTH);
      2:       return DELAY_W'(-HIST_DEPTH);
      3:       return DELAY_W'($urandom);  // may exceed the depth
      4:       return $urandom_range(1) ? DELAY_W'(1) : DELAY_W'(-1);
      default: return DELAY_W'(int'($urandom_range(2 * HIST_DEPTH)) - HIST_DEPTH);
    endcase
  endfunction

  // ---------------- tests ----------------

  task automatic test_reset_defaults();
    // reset mode follows chosen_channel
    send_pair(16'sh7FFF, 16'sh8000, 1'b0);
    send_pair(16'sh7FFF, 16'sh8000, 1'b1);
    send_pair(16'sh5555, -16'sh2AAB, 1'b0);
    wait_drained();
  endtask

  task automatic test_fixed_modes();
    configure(MODE_LEFT, '0);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    wait_drained();
    configure(MODE_RIGHT, '0);
    send_pair(16'sh8000, 16'sh7FFF, 1'b0);
    wait_drained();
    configure(MODE_AVERAGE, '0);
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(-16'sd3, 16'sd0, 1'b0);   // truncation toward zero on a negative sum
    send_pair(16'sd3, -16'sd4, 1'b1);
    wait_drained();
    configure(MODE_SPARE_A, '0);
    send_pair(16'sh7FFF, 16'sh8000, 1'b1);
    wait_drained();
    configure(MODE_SPARE_B, '0);
    send_pair(-16'sd101, 16'sd20, 1'b0);
    wait_drained();
    configure(MODE_SPARE_C, '0);
    send_pair(16'sd1, 16'sd2, 1'b1);
    wait_drained();
  endtask

  task automatic test_delay_sum();
    // zero delay leaves the history untouched
    configure(MODE_DSUM, '0);
    send_pair(16'sd100, -16'sd300, 1'b0);
    wait_drained();
    // fresh history reads as zero before the delayed sample shows up
    configure(MODE_DSUM, DELAY_W'(2));
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh7FFF, 16'sd1234, 1'b0);
    wait_drained();
    configure(MODE_DSUM, DELAY_W'(-2));
    send_pair(16'sd77, 16'sh8000, 1'b0);
    send_pair(-16'sd5, 16'sh7FFF, 1'b1);
    wait_drained();
    configure(MODE_DSUM, DELAY_W'(HIST_DEPTH));
    send_pair(16'sd9, -16'sd9, 1'b0);
    wait_drained();
    // magnitudes past the depth clamp to the oldest entry
    configure(MODE_DSUM, DELAY_W'(127));
    send_pair(16'sh4000, 16'sh2000, 1'b0);
    wait_drained();
    configure(MODE_DSUM, DELAY_W'(-128));
    send_pair(-16'sd4000, 16'sh7FFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items);
    int   sent;
    int   phase_end;
    int   burst;
    logic no_gaps;
    sent = 0;
    while (sent < n_items) begin
      wait_drained();
      configure(random_mode(), random_delay());
      no_gaps   = ($urandom_range(3) == 0);
      phase_end = sent + $urandom_range(40, 160);
      while (sent < phase_end && sent < n_items) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          send_pair(random_sample(), random_sample(), 1'($urandom_range(1)));
          sent++;
        end
        if ($urandom_range(9) == 0) wait_drained();
        else if (!no_gaps && $urandom_range(1)) idle_cycles($urandom_range(1, 8));
      end
    end
    wait_drained();
  endtask

  // ---------------- result checking ----------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mono_expected_q.size() == 0) begin
        $error("mono_sample: expected none, actual %0d", mono_sample_o);
        err_count++;
      end else if (mono_sample_o !== mono_expected_q[0]) begin
        $error("mono_sample: expected %0d, actual %0d", mono_expected_q[0], mono_sample_o);
        err_count++;
        void'(mono_expected_q.pop_front());
      end else begin
        void'(mono_expected_q.pop_front());
      end
    end
  end

  // receiver stall pattern, in one of four styles redrawn at random
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 128 == 0) stall_style <= $urandom_range(3);
    case (stall_style)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(99) < 30);
      2:       out_stall_i <= ($urandom_range(99) < 85);
      default: out_stall_i <= (stall_cycle % 5 < 2);
    endcase
  end

  // watchdog on cycles without any input, output or config handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
    if (idle_count >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    left_sample_i    = '0;
    right_sample_i   = '0;
    chosen_channel_i = 1'b0;
    out_stall_i      = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    err_count        = 0;
    idle_count       = 0;
    stall_cycle      = 0;
    stall_style      = 0;
    mode_q           = MIX_MODE_RESET;
    delay_q          = DELAY_RESET;
    hist_ptr         = 0;
    foreach (left_hist[i]) begin
      left_hist[i]  = '0;
      right_hist[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_fixed_modes();
    test_delay_sum();
    test_random_traffic(1300);

    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
